// File: hdl/alsdp_pkg.sv
`default_nettype none

package alsdp_pkg;

    localparam int MAX_STATIONS = 32;
    localparam int TIME_BITS = 16;

    localparam int FIELD_BITS = 16;
    localparam int COST_BITS = 24;
    localparam int EXIT_BITS = COST_BITS + 1;
    localparam int SUM_BITS = COST_BITS + 2;
    localparam int IDX_BITS = 6;
    localparam int CFG_IDX_BITS = 2;
    localparam int CNT_BITS = $clog2(MAX_STATIONS + 1);
    localparam int ADDR_BITS = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;

    localparam logic [FIELD_BITS-1:0] TIME_MASK = (TIME_BITS >= FIELD_BITS) ?
        {FIELD_BITS{1'b1}} : FIELD_BITS'((32'd1 << TIME_BITS) - 32'd1);
    localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

    localparam logic [CFG_IDX_BITS-1:0] REG_ENTRY_LINE1 = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ENTRY_LINE2 = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_EXIT_LINE1  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_EXIT_LINE2  = 2'd3;

    typedef struct packed {
        logic accept;
        logic final_step;
        logic trace_step;
        logic emit_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic full;
        logic single;
        logic trace_last;
        logic emit_last;
    } dp_sts_t;

    function automatic logic [FIELD_BITS-1:0] tmask(input logic [FIELD_BITS-1:0] v);
        return v & TIME_MASK;
    endfunction

    function automatic logic [COST_BITS-1:0] sat_cost(input logic [SUM_BITS-1:0] v);
        logic [COST_BITS-1:0] r;
        r = (v > SUM_BITS'(COST_MAX)) ? COST_MAX : v[COST_BITS-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/alsdp_ram.sv
`default_nettype none

module alsdp_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: hdl/alsdp_ctrl.sv
`default_nettype none

module alsdp_ctrl
    import alsdp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire logic    last_station,
    input  wire dp_sts_t sts,
    output ctrl_cmd_t    cmd,
    output logic         busy
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FINAL = 2'd1;
    localparam logic [1:0] S_TRACE = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (last_station || sts.full)
                    begin
                        state_next = S_FINAL;
                    end
                end
            end
            S_FINAL:
            begin
                cmd.final_step = 1'b1;
                state_next = sts.single ? S_EMIT : S_TRACE;
            end
            S_TRACE:
            begin
                cmd.trace_step = 1'b1;
                if (sts.trace_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit_step = 1'b1;
                if (sts.emit_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// File: hdl/alsdp_dp.sv
`default_nettype none

module alsdp_dp
    import alsdp_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire ctrl_cmd_t               cmd,
    output dp_sts_t                      sts,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [FIELD_BITS-1:0]   cfg_data,
    input  wire logic [FIELD_BITS-1:0]   line1_time,
    input  wire logic [FIELD_BITS-1:0]   line2_time,
    input  wire logic [FIELD_BITS-1:0]   transfer_from_line1,
    input  wire logic [FIELD_BITS-1:0]   transfer_from_line2,
    output logic                         result_valid,
    output logic                         is_total,
    output logic [COST_BITS-1:0]         total_time,
    output logic [IDX_BITS-1:0]          station_index,
    output logic                         chosen_line,
    output logic                         last_result
);

    logic [FIELD_BITS-1:0] entry1_reg, entry2_reg, exit1_reg, exit2_reg;
    logic [COST_BITS-1:0]  best1_reg, best2_reg, best1_next, best2_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [ADDR_BITS-1:0]  t_reg, t_next, k_reg, k_next, last_idx_reg, last_idx_next;
    logic                  cur_reg, cur_next;

    logic                  valid_reg, is_total_reg, last_reg;
    logic [COST_BITS-1:0]  total_reg;
    logic [IDX_BITS-1:0]   index_reg;

    logic [SUM_BITS-1:0]   a1, a2, t1, t2, c1, c2;
    logic [SUM_BITS-1:0]   stay1, cross1, stay2, cross2, first1, first2;
    logic [1:0]            pred;
    logic [EXIT_BITS-1:0]  f1, f2;
    logic                  cur_f, cur_new;
    logic [COST_BITS-1:0]  total_f;
    logic [ADDR_BITS-1:0]  last_idx_w, idx_w, t_dec;
    logic [1:0]            pred_q;
    logic                  route_q;

    // station recurrence
    always_comb
    begin
        a1 = SUM_BITS'(tmask(line1_time));
        a2 = SUM_BITS'(tmask(line2_time));
        t1 = SUM_BITS'(tmask(transfer_from_line1));
        t2 = SUM_BITS'(tmask(transfer_from_line2));
        c1 = SUM_BITS'(best1_reg);
        c2 = SUM_BITS'(best2_reg);
        stay1 = c1 + a1;
        cross1 = c2 + a1 + t2;
        stay2 = c2 + a2;
        cross2 = c1 + a2 + t1;
        first1 = SUM_BITS'(tmask(entry1_reg)) + a1;
        first2 = SUM_BITS'(tmask(entry2_reg)) + a2;
        if (count_reg == '0)
        begin
            pred = 2'b00;
            best1_next = sat_cost(first1);
            best2_next = sat_cost(first2);
        end
        else
        begin
            pred[0] = (stay1 > cross1);
            pred[1] = !(stay2 > cross2);
            best1_next = sat_cost(pred[0] ? cross1 : stay1);
            best2_next = sat_cost(pred[1] ? stay2 : cross2);
        end
    end

    // exit costs and line choice
    always_comb
    begin
        f1 = EXIT_BITS'(best1_reg) + EXIT_BITS'(tmask(exit1_reg));
        f2 = EXIT_BITS'(best2_reg) + EXIT_BITS'(tmask(exit2_reg));
        cur_f = !(f1 < f2);
        total_f = sat_cost(SUM_BITS'(cur_f ? f2 : f1));
        last_idx_w = ADDR_BITS'(count_reg - CNT_BITS'(1));
        idx_w = ADDR_BITS'(count_reg);
        t_dec = t_reg - ADDR_BITS'(1);
        cur_new = pred_q[cur_reg];
    end

    alsdp_ram #(.WIDTH(2), .DEPTH(MAX_STATIONS)) u_pred_ram (
        .clk     (clk),
        .wr_en   (cmd.accept),
        .wr_addr (idx_w),
        .wr_data (pred),
        .rd_addr (cmd.final_step ? last_idx_w : t_dec),
        .rd_data (pred_q)
    );

    alsdp_ram #(.WIDTH(1), .DEPTH(MAX_STATIONS)) u_route_ram (
        .clk     (clk),
        .wr_en   (cmd.final_step || cmd.trace_step),
        .wr_addr (cmd.final_step ? last_idx_w : t_dec),
        .wr_data (cmd.final_step ? cur_f : cur_new),
        .rd_addr (k_reg),
        .rd_data (route_q)
    );

    always_comb
    begin
        count_next = count_reg;
        t_next = t_reg;
        k_next = k_reg;
        last_idx_next = last_idx_reg;
        cur_next = cur_reg;
        if (cmd.accept)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        if (cmd.final_step)
        begin
            count_next = '0;
            t_next = last_idx_w;
            k_next = '0;
            last_idx_next = last_idx_w;
            cur_next = cur_f;
        end
        if (cmd.trace_step)
        begin
            t_next = t_dec;
            cur_next = cur_new;
        end
        if (cmd.emit_step)
        begin
            k_next = k_reg + ADDR_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry1_reg <= '0;
            entry2_reg <= '0;
            exit1_reg <= '0;
            exit2_reg <= '0;
            best1_reg <= '0;
            best2_reg <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ENTRY_LINE1: entry1_reg <= cfg_data;
                    REG_ENTRY_LINE2: entry2_reg <= cfg_data;
                    REG_EXIT_LINE1:  exit1_reg <= cfg_data;
                    REG_EXIT_LINE2:  exit2_reg <= cfg_data;
                    default:         entry1_reg <= entry1_reg;
                endcase
            end
            if (cmd.accept)
            begin
                best1_reg <= best1_next;
                best2_reg <= best2_next;
            end
            else if (cmd.final_step)
            begin
                best1_reg <= '0;
                best2_reg <= '0;
            end
            count_reg <= count_next;
            valid_reg <= cmd.final_step || cmd.emit_step;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
        k_reg <= k_next;
        last_idx_reg <= last_idx_next;
        cur_reg <= cur_next;
        is_total_reg <= cmd.final_step;
        total_reg <= cmd.final_step ? total_f : '0;
        index_reg <= cmd.emit_step ? (IDX_BITS'(k_reg) + IDX_BITS'(1)) : '0;
        last_reg <= cmd.emit_step && (k_reg == last_idx_reg);
    end

    assign sts.full = (count_reg == CNT_BITS'(MAX_STATIONS - 1));
    assign sts.single = (count_reg == CNT_BITS'(1));
    assign sts.trace_last = (t_reg == ADDR_BITS'(1));
    assign sts.emit_last = (k_reg == last_idx_reg);

    assign result_valid = valid_reg;
    assign is_total = is_total_reg;
    assign total_time = total_reg;
    assign station_index = index_reg;
    assign chosen_line = is_total_reg ? 1'b0 : route_q;
    assign last_result = last_reg;

endmodule

`default_nettype wire

// File: hdl/assembly_line_schedule_dp.sv
// two-line assembly-line scheduler
// configuration: cfg_we writes cfg_data into register cfg_index (entry cost
// line 1, entry cost line 2, exit cost line 1, exit cost line 2); the user
// must write only while busy is low, the block does not enforce it
// request: one station per cycle, taken when start is high and busy is low;
// a station with last_station set, or the buffer-full station, closes the
// problem
// results: result_valid marks each result for exactly one cycle; there is no
// back-pressure, the receiver takes every result in the cycle it appears
// sequence: ordinary stations give no result; after the closing station the
// final state registers the total onto the outputs, a traceback through the
// predecessor RAM (skipped for a single station) fills the route RAM, then
// the route of n stations comes out one per cycle, and the last route
// result shows in the first cycle after busy drops
// a new problem is taken only after busy drops, once the route of the last
// problem has been read out of the route RAM
// reset: costs, the station counter and configuration clear; trace and route
// indices are not reset; RAM contents are only read after being written
`default_nettype none

module assembly_line_schedule_dp
    import alsdp_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [FIELD_BITS-1:0]   cfg_data,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [FIELD_BITS-1:0]   line1_time,
    input  wire logic [FIELD_BITS-1:0]   line2_time,
    input  wire logic [FIELD_BITS-1:0]   transfer_from_line1,
    input  wire logic [FIELD_BITS-1:0]   transfer_from_line2,
    input  wire logic                    last_station,
    output logic                         result_valid,
    output logic                         is_total,
    output logic [COST_BITS-1:0]         total_time,
    output logic [IDX_BITS-1:0]          station_index,
    output logic                         chosen_line,
    output logic                         last_result
);

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    alsdp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .last_station (last_station),
        .sts          (sts),
        .cmd          (cmd),
        .busy         (busy)
    );

    alsdp_dp u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .sts                 (sts),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .line1_time          (line1_time),
        .line2_time          (line2_time),
        .transfer_from_line1 (transfer_from_line1),
        .transfer_from_line2 (transfer_from_line2),
        .result_valid        (result_valid),
        .is_total            (is_total),
        .total_time          (total_time),
        .station_index       (station_index),
        .chosen_line         (chosen_line),
        .last_result         (last_result)
    );

    // a station with last_station set always raises busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_station) |=> busy)
        else $error("closing station did not raise busy");

    // total result only shows while the run is still busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && is_total) |-> busy)
        else $error("total result outside a run");

    // an idle cycle is never followed by a total result
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !(result_valid && is_total))
        else $error("total result without a closing step");

    // the final route step never carries the total
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_result) |-> !is_total)
        else $error("last result marked as total");

endmodule

`default_nettype wire
